// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define EGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that one condition is followed by another in the next cycle.
`define EGC_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/egc_pkg.sv =====
`default_nettype none
package egc_pkg;

	// Request codes.
	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_APPLY  = 3'd2;
	localparam logic [2:0] REQ_LOAD   = 3'd3;
	localparam logic [2:0] REQ_INCR   = 3'd4;
	localparam logic [2:0] REQ_DONE   = 3'd5;

	// Status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_ID     = 3'd1;
	localparam logic [2:0] ST_NOT_FREE   = 3'd2;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
	localparam logic [2:0] ST_COUNT_ZERO = 3'd4;
	localparam logic [2:0] ST_NO_FREE    = 3'd5;
	localparam logic [2:0] ST_SATURATED  = 3'd6;
	localparam logic [2:0] ST_BAD_SLOT   = 3'd7;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  group_id;
		logic [31:0] amount;
		logic [7:0]  notif_total;
		logic [2:0]  notif_slot;
		logic [31:0] notif_event;
		logic [15:0] notif_queue;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  new_group;
		logic        group_valid;
		logic        notify_valid;
		logic [31:0] notify_event;
		logic [15:0] notify_queue;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CNT,
		S_RESULT,
		S_EMIT_RD,
		S_EMIT_WR
	} state_t;

endpackage
`default_nettype wire

// ===== sv/egc_ram.sv =====
`default_nettype none
module egc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/event_group_completion_table.sv =====
// Channel | Direction | Valid     | Stall     | Payload
// req     | in        | req_valid | req_stall | egc_pkg::req_t
// rsp     | out       | rsp_valid | rsp_stall | egc_pkg::rsp_t
//
// One request is handled at a time. Delete, load, a bad id or an unused code go
// straight to the result; apply, increment and a completion first pass the
// count state (one count memory read and write back). Create first runs the free
// scan over up to ceil(GROUPS/8) chunks, checking eight allocated flags a cycle.
// A completion releasing n notifications sends n beats, one memory read per beat.
// Reset clears allocated flags and count valid bits at once; no clearing pass.
// A stalled response beat holds the output register and the sequencer waits.
`default_nettype none
module event_group_completion_table #(
	parameter int GROUPS    = 64,
	parameter int MAX_NOTIF = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire egc_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output egc_pkg::rsp_t      rsp
);

	localparam int GW  = $clog2(GROUPS);
	localparam int NCW = $clog2(MAX_NOTIF + 1);
	localparam int NAW = $clog2(GROUPS * MAX_NOTIF);
	localparam int CW  = 32 + NCW;
	localparam int NCH = (GROUPS + 7) / 8;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int IW  = CHW + 3;

	egc_pkg::state_t state_q, state_d;
	egc_pkg::req_t   req_q, req_d;
	egc_pkg::rsp_t   res_q, res_d, out_q, out_d;
	logic            out_valid_q, out_ld;
	logic [GROUPS-1:0] flags_q, cvld_q;
	logic            flag_set, flag_clr;
	logic [CHW-1:0]  ch_q, ch_d;
	logic [NCW-1:0]  k_q, k_d, n_q, n_d;
	logic [NAW-1:0]  base_q, base_d;
	logic            cvld_s1;
	logic            acc, out_free, gid_ok_in, gid_ok_q, slot_ok;
	logic [GW-1:0]   gidx_in, gidx_q;

	// Count memory ports.
	logic            cwe;
	logic [CW-1:0]   cwdata, crdata;
	logic [31:0]     pend;
	logic [NCW-1:0]  ncnt;
	logic [32:0]     sum;

	// Notification memory ports.
	logic            nwe;
	logic [NAW-1:0]  nwaddr, nraddr;
	logic [47:0]     nrdata;

	// Free scan over one chunk of eight flags.
	logic            hit;
	logic [GW-1:0]   hit_idx;
	logic [IW-1:0]   scan_idx;

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != egc_pkg::S_IDLE);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign gid_ok_in = ({1'b0, req.group_id} < 9'(GROUPS));
	assign gid_ok_q  = ({1'b0, req_q.group_id} < 9'(GROUPS));
	assign gidx_in   = req.group_id[GW-1:0];
	assign gidx_q    = req_q.group_id[GW-1:0];
	assign slot_ok   = ({4'd0, req.notif_slot} < 7'(MAX_NOTIF));
	assign nwaddr    = NAW'(gidx_in * MAX_NOTIF) + NAW'(req.notif_slot);
	assign nraddr    = base_q + NAW'(k_q);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	egc_ram #(.WIDTH(CW), .DEPTH(GROUPS)) u_cnt_ram (
		.clk   (clk),
		.we    (cwe),
		.waddr (gidx_q),
		.wdata (cwdata),
		.raddr (gidx_in),
		.rdata (crdata)
	);

	egc_ram #(.WIDTH(48), .DEPTH(GROUPS * MAX_NOTIF)) u_notif_ram (
		.clk   (clk),
		.we    (nwe),
		.waddr (nwaddr),
		.wdata ({req.notif_event, req.notif_queue}),
		.raddr (nraddr),
		.rdata (nrdata)
	);

	// Lowest free group within the current chunk.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		scan_idx = '0;
		for (int j = 0; j < 8; j++) begin
			scan_idx = {ch_q, 3'(j)};
			if (!hit && ({1'b0, scan_idx} < (IW + 1)'(GROUPS)) &&
					!flags_q[scan_idx[GW-1:0]]) begin
				hit     = 1'b1;
				hit_idx = scan_idx[GW-1:0];
			end
		end
	end

	// An entry never written reads as zero.
	assign pend = cvld_s1 ? crdata[31:0] : 32'd0;
	assign ncnt = cvld_s1 ? crdata[CW-1:32] : '0;
	assign sum  = {1'b0, pend} + {1'b0, req_q.amount};

	// Sequencer: next state and strobes.
	always_comb begin
		state_d  = state_q;
		req_d    = req_q;
		res_d    = res_q;
		out_d    = out_q;
		out_ld   = 1'b0;
		ch_d     = ch_q;
		k_d      = k_q;
		n_d      = n_q;
		base_d   = base_q;
		flag_set = 1'b0;
		flag_clr = 1'b0;
		cwe      = 1'b0;
		cwdata   = {ncnt, pend};
		nwe      = 1'b0;
		case (state_q)
			egc_pkg::S_IDLE: begin
				if (acc) begin
					req_d = req;
					res_d = '0;
					res_d.last = 1'b1;
					res_d.status = egc_pkg::ST_OK;
					state_d = egc_pkg::S_RESULT;
					case (req.req_type)
						egc_pkg::REQ_CREATE: begin
							ch_d = '0;
							state_d = egc_pkg::S_SCAN;
						end
						egc_pkg::REQ_DELETE: begin
							if (gid_ok_in) begin
								flag_clr = 1'b1;
							end else begin
								res_d.status = egc_pkg::ST_BAD_ID;
							end
						end
						egc_pkg::REQ_APPLY, egc_pkg::REQ_INCR, egc_pkg::REQ_DONE: begin
							if (gid_ok_in) begin
								state_d = egc_pkg::S_CNT;
							end else begin
								res_d.status = egc_pkg::ST_BAD_ID;
							end
						end
						egc_pkg::REQ_LOAD: begin
							if (!gid_ok_in) begin
								res_d.status = egc_pkg::ST_BAD_ID;
							end else if (!slot_ok) begin
								res_d.status = egc_pkg::ST_BAD_SLOT;
							end else begin
								nwe = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			egc_pkg::S_SCAN: begin
				if (hit) begin
					flag_set = 1'b1;
					res_d.new_group = 6'(hit_idx);
					res_d.group_valid = 1'b1;
					state_d = egc_pkg::S_RESULT;
				end else if (ch_q == CHW'(NCH - 1)) begin
					res_d.status = egc_pkg::ST_NO_FREE;
					state_d = egc_pkg::S_RESULT;
				end else begin
					ch_d = ch_q + CHW'(1);
				end
			end
			egc_pkg::S_CNT: begin
				state_d = egc_pkg::S_RESULT;
				case (req_q.req_type)
					egc_pkg::REQ_APPLY: begin
						if (pend != 32'd0) begin
							res_d.status = egc_pkg::ST_NOT_FREE;
						end else if (req_q.notif_total > 8'(MAX_NOTIF)) begin
							res_d.status = egc_pkg::ST_TOO_LARGE;
						end else begin
							cwe = 1'b1;
							cwdata = {req_q.notif_total[NCW-1:0], req_q.amount};
						end
					end
					egc_pkg::REQ_INCR: begin
						cwe = 1'b1;
						if (sum[32]) begin
							res_d.status = egc_pkg::ST_SATURATED;
							cwdata = {ncnt, 32'hFFFF_FFFF};
						end else begin
							cwdata = {ncnt, sum[31:0]};
						end
					end
					default: begin
						if (pend == 32'd0) begin
							res_d.status = egc_pkg::ST_COUNT_ZERO;
						end else begin
							cwe = 1'b1;
							cwdata = {ncnt, pend - 32'd1};
							if (pend == 32'd1 && ncnt != '0) begin
								n_d = ncnt;
								k_d = '0;
								base_d = NAW'(gidx_q * MAX_NOTIF);
								state_d = egc_pkg::S_EMIT_RD;
							end
						end
					end
				endcase
			end
			egc_pkg::S_RESULT: begin
				if (out_free) begin
					out_ld = 1'b1;
					out_d = res_q;
					state_d = egc_pkg::S_IDLE;
				end
			end
			egc_pkg::S_EMIT_RD: begin
				if (out_free) begin
					state_d = egc_pkg::S_EMIT_WR;
				end
			end
			egc_pkg::S_EMIT_WR: begin
				out_ld = 1'b1;
				out_d = '0;
				out_d.status = egc_pkg::ST_OK;
				out_d.notify_valid = 1'b1;
				out_d.notify_event = nrdata[47:16];
				out_d.notify_queue = nrdata[15:0];
				out_d.last = (k_q == n_q - NCW'(1));
				k_d = k_q + NCW'(1);
				state_d = out_d.last ? egc_pkg::S_IDLE : egc_pkg::S_EMIT_RD;
			end
			default: begin
				state_d = egc_pkg::S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
			cvld_q      <= '0;
		end else begin
			state_q <= state_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (flag_set) begin
				flags_q[hit_idx] <= 1'b1;
			end
			if (flag_clr) begin
				flags_q[gidx_in] <= 1'b0;
			end
			if (cwe) begin
				cvld_q[gidx_q] <= 1'b1;
			end
		end
	end

	// Request, result and sequencing payload.
	always_ff @(posedge clk) begin
		req_q   <= req_d;
		res_q   <= res_d;
		ch_q    <= ch_d;
		k_q     <= k_d;
		n_q     <= n_d;
		base_q  <= base_d;
		cvld_s1 <= gid_ok_in && cvld_q[gidx_in];
		if (out_ld) begin
			out_q <= out_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/egc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module egc_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire egc_pkg::rsp_t rsp
);

	// A stalled response beat holds.
	`EGC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed under stall")

	// The table takes one request at a time.
	`EGC_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while busy")

	// Only a successful create reports a group.
	`EGC_ASSERT(a_group_ok, rsp_valid && rsp.group_valid |-> rsp.status == egc_pkg::ST_OK, "group with error status")

	// Only notification beats come before the last beat.
	`EGC_ASSERT(a_burst, rsp_valid && !rsp.last |-> rsp.notify_valid, "non-last beat without notification")

	// A notification beat never carries a group.
	`EGC_ASSERT(a_notify_clean, rsp_valid && rsp.notify_valid |-> !rsp.group_valid && rsp.status == egc_pkg::ST_OK, "bad notification beat")

endmodule

bind event_group_completion_table egc_checker u_egc_checker (.*);
`default_nettype wire
